// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the Life step unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while the reset is high.
`define LCAS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, switched off while the reset is high.
`define LCAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// File: rtl/lcas_pkg.sv
// Package for the Life step unit: sizes, register indexes, shared types
// and the B3/S23 rule function. No dependencies.
package lcas_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
  localparam int SIZE_W      = 11;
  localparam int COUNT_W     = 21;
  localparam int GEN_W       = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd800;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd500;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [GEN_W-1:0]   gen_t;

  // Per-item control word produced by the scan counters.
  typedef struct packed {
    col_t col;
    logic cin;
    logic up_ok;
    logic mid_ok;
    logic row_start;
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic   out_valid;
    logic   next_alive;
    logic   out_last;
    count_t live_count;
    gen_t   generation;
  } result_t;

  // Window bit 3*column+row; bit 4 is the center cell.
  function automatic logic life_rule(input logic [8:0] win);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + 4'(win[4'(i)]);
    end
    return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && win[4]);
  endfunction

endpackage

// File: rtl/lcas_if.sv
// Valid/ready channel interfaces for the Life step unit.
// Depends on lcas_pkg.
interface lcas_in_if;
  import lcas_pkg::*;
  logic valid;
  logic ready;
  logic cell_alive;
  logic flush;
  modport source(output valid, output cell_alive, output flush, input ready);
  modport sink(input valid, input cell_alive, input flush, output ready);
endinterface

interface lcas_out_if;
  import lcas_pkg::*;
  logic   valid;
  logic   ready;
  logic   out_valid;
  logic   next_alive;
  logic   out_last;
  count_t live_count;
  gen_t   generation;
  modport source(output valid, output out_valid, output next_alive, output out_last,
                 output live_count, output generation, input ready);
  modport sink(input valid, input out_valid, input next_alive, input out_last,
               input live_count, input generation, output ready);
endinterface

// File: rtl/lcas_line_store.sv
// Two-bit-wide line store: bit 1 holds the upper row, bit 0 the middle row.
// One registered read port and one write port. Depends on lcas_pkg.
module lcas_line_store (
  input  logic          clk,
  input  logic          rd_en,
  input  lcas_pkg::col_t rd_addr,
  output logic [1:0]    rd_data,
  input  logic          wr_en,
  input  lcas_pkg::col_t wr_addr,
  input  logic [1:0]    wr_data
);
  import lcas_pkg::*;

  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/lcas_scan.sv
// Size registers and raster position counters of the Life step unit.
// Produces the per-item control word. Depends on lcas_pkg.
module lcas_scan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lcas_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  lcas_pkg::size_t                    cfg_data,
  input  logic                               advance,
  input  logic                               cell_alive,
  input  logic                               flush,
  output lcas_pkg::tag_t                     tag,
  output logic                               restart
);
  import lcas_pkg::*;

  size_t          grid_width;
  size_t          grid_height;
  col_t           col;
  row_t           row;
  col_t           col_next;
  row_t           row_next;
  logic [COL_W:0] w_eff;
  row_t           h_eff;
  row_t           h_plus1;
  logic [COL_W:0] col_inc;

  always_comb begin
    if (grid_width == '0) w_eff = (COL_W+1)'(1);
    else if (int'(grid_width) > MAX_WIDTH) w_eff = (COL_W+1)'(MAX_WIDTH);
    else w_eff = (COL_W+1)'(grid_width);

    if (grid_height == '0) h_eff = ROW_W'(1);
    else if (int'(grid_height) > MAX_HEIGHT) h_eff = ROW_W'(MAX_HEIGHT);
    else h_eff = ROW_W'(grid_height);

    h_plus1 = h_eff + ROW_W'(1);
    col_inc = {1'b0, col} + (COL_W+1)'(1);

    tag.col       = col;
    tag.cin       = cell_alive && !flush && (row < h_eff);
    tag.up_ok     = row >= ROW_W'(2);
    tag.mid_ok    = row != '0;
    tag.row_start = col == '0;
    tag.valid     = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
    tag.last      = (row == h_plus1) && (col == '0);

    if (tag.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc == w_eff) begin
      col_next = '0;
      row_next = row + ROW_W'(1);
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row;
    end
  end

  assign restart = cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RESET_WIDTH;
      grid_height <= RESET_HEIGHT;
      col         <= '0;
      row         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// File: rtl/lcas_window.sv
// 3x3 neighbor window, Life rule evaluation, live and generation counters
// and the output register. Depends on lcas_pkg.
module lcas_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              go,
  input  lcas_pkg::tag_t    tag,
  input  logic [1:0]        store_data,
  output lcas_pkg::result_t result
);
  import lcas_pkg::*;

  logic [8:0] win;
  logic [8:0] win_next;
  logic [8:0] eval;
  logic [2:0] column;
  logic       nxt;
  count_t     live;
  count_t     live_next;
  gen_t       gen;
  gen_t       gen_next;

  always_comb begin
    column = {tag.cin, tag.mid_ok & store_data[0], tag.up_ok & store_data[1]};
    if (tag.row_start) begin
      // The emitted cell ends its row, so its right column lies outside.
      eval     = {3'b000, win[8:3]};
      win_next = {column, 6'b000000};
    end else begin
      win_next = {column, win[8:3]};
      eval     = win_next;
    end
    nxt       = tag.valid && life_rule(eval);
    live_next = live + COUNT_W'(nxt);
    gen_next  = gen + GEN_W'(tag.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= '0;
      live <= '0;
      gen  <= '0;
    end else if (restart) begin
      win  <= '0;
      live <= '0;
    end else if (go) begin
      win  <= tag.last ? '0 : win_next;
      live <= tag.last ? '0 : live_next;
      gen  <= gen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result.out_valid  <= tag.valid;
      result.next_alive <= nxt;
      result.out_last   <= tag.last;
      result.live_count <= live_next;
      result.generation <= gen_next;
    end
  end

endmodule

// File: rtl/life_cellular_automaton_step_unit.sv
// Top level of the Life (B3/S23) streaming step unit.
// Depends on lcas_pkg, lcas_if, lcas_scan, lcas_line_store, lcas_window.
//
//   channel   dir  handshake            payload
//   cells     in   valid/ready          cell_alive, flush
//   results   out  valid/ready          out_valid, next_alive, out_last,
//                                       live_count, generation
//   cfg_*     in   cfg_write (no wait)  cfg_index, cfg_data
//
// One cell transfer per clock is sustained while results are taken; each result
// passes through the line store read and then the output register.
// The line stores sit in one memory read and written back once per cell;
// a cell of a one-wide grid that hits the entry being written in the same
// cycle takes the written value through a one-entry bypass.
// Reset is synchronous and needs no clearing pass: store entries are only
// used after they have been written within the current generation.
// A stall on the result side holds the output register, and the input keeps
// taking cells until the middle stage is also full.
module life_cellular_automaton_step_unit (
  input  logic                             clk,
  input  logic                             rst,
  lcas_in_if.sink                          cells,
  lcas_out_if.source                       results,
  input  logic                             cfg_write,
  input  logic [lcas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  lcas_pkg::size_t                  cfg_data
);
  import lcas_pkg::*;

  tag_t       tag0;
  tag_t       s1_tag;
  logic       s1_valid;
  logic       s2_valid;
  logic       s1_go;
  logic       accept;
  logic       restart;
  logic [1:0] rd_data;
  logic [1:0] store_data;
  logic [1:0] wr_data;
  logic       fwd_hit;
  logic [1:0] fwd_data;
  result_t    result;

  // The middle stage moves on whenever the output register is free or drains.
  assign s1_go        = s1_valid && (!s2_valid || results.ready);
  assign cells.ready  = !s1_valid || s1_go;
  assign accept       = cells.valid && cells.ready;

  lcas_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (accept),
    .cell_alive (cells.cell_alive),
    .flush      (cells.flush),
    .tag        (tag0),
    .restart    (restart)
  );

  // The column is read when the cell transfers and written back when its
  // stage moves on: upper takes the old middle, middle takes the new cell.
  lcas_line_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (tag0.col),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_tag.col),
    .wr_data (wr_data)
  );

  assign store_data = fwd_hit ? fwd_data : rd_data;
  assign wr_data    = {store_data[0], s1_tag.cin};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cells.ready) s1_valid <= cells.valid;
      if (s1_go) s2_valid <= 1'b1;
      else if (results.ready) s2_valid <= 1'b0;
    end
  end

  // The read and a write-back to the same entry in one cycle return stale
  // data, so the written value is captured for the new cell instead.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag   <= tag0;
      fwd_hit  <= s1_go && (s1_tag.col == tag0.col);
      fwd_data <= wr_data;
    end
  end

  lcas_window u_window (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .go         (s1_go),
    .tag        (s1_tag),
    .store_data (store_data),
    .result     (result)
  );

  assign results.valid      = s2_valid;
  assign results.out_valid  = result.out_valid;
  assign results.next_alive = result.next_alive;
  assign results.out_last   = result.out_last;
  assign results.live_count = result.live_count;
  assign results.generation = result.generation;

endmodule

// File: rtl/lcas_checker.sv
// Port-level checker for the Life step unit, bound to the top level.
// Depends on lcas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcas_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic             out_valid,
  input logic             next_alive,
  input logic             out_last,
  input lcas_pkg::count_t live_count,
  input lcas_pkg::gen_t   generation
);
  import lcas_pkg::*;

  logic                     stalled;
  logic [COUNT_W+GEN_W+2:0] payload;
  assign stalled = res_valid && !res_ready;
  assign payload = {out_valid, next_alive, out_last, live_count, generation};

  // A stalled result keeps its whole payload.
  `LCAS_ASSERT_NEXT(a_hold, clk, rst, stalled, res_valid && $stable(payload))
  // Reset empties the output register.
  `LCAS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid)
  // With no result waiting the input side is never held off.
  `LCAS_ASSERT_IMP(a_no_block, clk, rst, !res_valid && in_valid, in_ready)
  // A live cell or the end of a generation only comes with a real cell.
  `LCAS_ASSERT_IMP(a_cell_flags, clk, rst, res_valid && (next_alive || out_last), out_valid)

endmodule

bind life_cellular_automaton_step_unit lcas_checker u_lcas_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cells.valid),
  .in_ready   (cells.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .out_valid  (results.out_valid),
  .next_alive (results.next_alive),
  .out_last   (results.out_last),
  .live_count (results.live_count),
  .generation (results.generation)
);
